@@ sv/oad_pkg.sv @@
package oad_pkg;

  typedef logic [4:0] state_code_t;

  // Drive states: an action state is even, its in-progress state is the next odd code
  localparam state_code_t ST_WAIT    = 5'd0;
  localparam state_code_t ST_WAITING = 5'd1;
  localparam state_code_t ST_FWD     = 5'd2;
  localparam state_code_t ST_FWD_RUN = 5'd3;
  localparam state_code_t ST_TURN_L  = 5'd4;
  localparam state_code_t ST_TURN_R  = 5'd6;
  localparam state_code_t ST_SPIN_L  = 5'd8;
  localparam state_code_t ST_SPIN_R  = 5'd10;
  localparam state_code_t ST_STOP    = 5'd12;
  localparam state_code_t ST_BACK    = 5'd14;
  localparam state_code_t ST_CORR_L  = 5'd16;
  localparam state_code_t ST_CORR_R  = 5'd18;
  localparam state_code_t ST_LIGHT_L = 5'd20;
  localparam state_code_t ST_LIGHT_R = 5'd22;
  localparam state_code_t ST_LAST    = 5'd23;
  localparam state_code_t ST_MAX     = 5'd31;

  typedef logic [1:0] req_t;
  localparam req_t REQ_TICK = 2'd0;
  localparam req_t REQ_AUTO = 2'd1;
  localparam req_t REQ_SET  = 2'd2;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TURN     = 3'd0;
  localparam cfg_idx_t CFG_SPIN     = 3'd1;
  localparam cfg_idx_t CFG_REVERSE  = 3'd2;
  localparam cfg_idx_t CFG_LIGHT    = 3'd3;
  localparam cfg_idx_t CFG_CORRIDOR = 3'd4;
  localparam cfg_idx_t CFG_MAX      = 3'd5;
  localparam cfg_idx_t CFG_MIN      = 3'd6;
  localparam cfg_idx_t CFG_WAIT     = 3'd7;

  localparam int CFG_DATA_W = 16;

  // LED bits: white, blue, amber
  localparam logic [2:0] LED_W = 3'b001;
  localparam logic [2:0] LED_B = 3'b010;
  localparam logic [2:0] LED_O = 3'b100;

  localparam logic [7:0] D_CENTER_NEAR = 8'd20;
  localparam logic [7:0] D_EDGE        = 8'd10;
  localparam logic [7:0] D_EDGE_CLOSE  = 8'd5;
  localparam logic [7:0] D_SIDE_NEAR   = 8'd20;
  localparam logic [7:0] D_SIDE_FAR    = 8'd30;
  localparam logic signed [8:0] SPEED_OFFSET = 9'sd10;
  localparam logic signed [8:0] SPEED_BLUE   = 9'sd30;
  localparam logic signed [8:0] SPEED_WHITE  = 9'sd20;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] cmd_value;
    logic [7:0] dist_right_edge;
    logic [7:0] dist_right;
    logic [7:0] dist_center;
    logic [7:0] dist_left;
    logic [7:0] dist_left_edge;
    logic [7:0] ms_delta;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        state_code;
    logic signed [7:0] right_speed;
    logic signed [7:0] left_speed;
    logic              led_white;
    logic              led_blue;
    logic              led_amber;
    logic              auto_mode;
    logic              state_report;
  } out_item_t;

endpackage

@@ sv/oad_in_if.sv @@
interface oad_in_if;
  logic               valid;
  logic               ready;
  oad_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/oad_out_if.sv @@
interface oad_out_if;
  logic               valid;
  logic               ready;
  oad_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/obstacle_avoid_drive_fsm.sv @@
// Reactive two-motor drive controller. Each request (loop tick, set-auto or
// set-state) is handled combinationally: the state, timer and latched
// speed/LED registers update at the edge where the request is taken, and the
// result lands in an output register in the same edge. One request per clock
// is taken as long as the result register is empty or being drained; a
// stalled result stalls the input. Configuration writes through the cfg_ port
// take effect on the next edge and must be issued only while no request is
// pending.
module obstacle_avoid_drive_fsm (
  input  logic                             clk,
  input  logic                             rst_n,
  oad_in_if.sink                           in_ch,
  oad_out_if.source                        out_ch,
  input  logic                             cfg_wr_en,
  input  oad_pkg::cfg_idx_t                cfg_index,
  input  logic [oad_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration
  logic [6:0]        turn_r, spin_r, light_r, corr_r, max_r, min_r;
  logic signed [7:0] rev_r;
  logic [15:0]       wait_ms_r;

  // drive state
  oad_pkg::state_code_t st_r, st_nxt;
  logic                 auto_r, auto_nxt;
  logic                 tog_r, tog_nxt;
  logic [15:0]          timer_r, timer_nxt;
  logic signed [7:0]    rcmd_r, rcmd_nxt, lcmd_r, lcmd_nxt;
  logic [2:0]           leds_r, leds_nxt;
  logic                 rep_nxt;

  oad_pkg::out_item_t out_r;
  logic               out_valid_r;
  logic               in_acc;

  oad_pkg::in_item_t  req;
  logic [16:0]        timer_sum;
  logic [15:0]        timer_sat;
  logic [7:0]         m01, m23, m0123, dmin;
  logic signed [8:0]  fwd_raw, fwd_s;
  logic [2:0]         fwd_leds;
  oad_pkg::state_code_t auto_pick;
  logic               auto_fwd;
  oad_pkg::state_code_t cur_run;
  logic               run_auto;
  logic signed [7:0]  spin_s, spin_neg;

  assign req       = in_ch.payload;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r    <= 7'd15;
      spin_r    <= 7'd15;
      rev_r     <= -8'sd15;
      light_r   <= 7'd20;
      corr_r    <= 7'd25;
      max_r     <= 7'd40;
      min_r     <= 7'd0;
      wait_ms_r <= 16'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        oad_pkg::CFG_TURN:     turn_r    <= cfg_wdata[6:0];
        oad_pkg::CFG_SPIN:     spin_r    <= cfg_wdata[6:0];
        oad_pkg::CFG_REVERSE:  rev_r     <= cfg_wdata[7:0];
        oad_pkg::CFG_LIGHT:    light_r   <= cfg_wdata[6:0];
        oad_pkg::CFG_CORRIDOR: corr_r    <= cfg_wdata[6:0];
        oad_pkg::CFG_MAX:      max_r     <= cfg_wdata[6:0];
        oad_pkg::CFG_MIN:      min_r     <= cfg_wdata[6:0];
        oad_pkg::CFG_WAIT:     wait_ms_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // saturating timer advance
  assign timer_sum = {1'b0, timer_r} + {9'd0, req.ms_delta};
  assign timer_sat = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];

  // forward speed: nearest reading minus offset, clamped
  assign m01   = (req.dist_right_edge < req.dist_right) ? req.dist_right_edge : req.dist_right;
  assign m23   = (req.dist_center < req.dist_left) ? req.dist_center : req.dist_left;
  assign m0123 = (m01 < m23) ? m01 : m23;
  assign dmin  = (m0123 < req.dist_left_edge) ? m0123 : req.dist_left_edge;
  assign fwd_raw = $signed({1'b0, dmin}) - oad_pkg::SPEED_OFFSET;

  always_comb begin
    if (fwd_raw > $signed({2'b00, max_r})) begin
      fwd_s = $signed({2'b00, max_r});
    end else if (fwd_raw < $signed({2'b00, min_r})) begin
      fwd_s = $signed({2'b00, min_r});
    end else begin
      fwd_s = fwd_raw;
    end
    if (fwd_s >= oad_pkg::SPEED_BLUE) begin
      fwd_leds = oad_pkg::LED_B;
    end else if (fwd_s >= oad_pkg::SPEED_WHITE) begin
      fwd_leds = oad_pkg::LED_W;
    end else begin
      fwd_leds = 3'b000;
    end
  end

  // obstacle classification
  always_comb begin
    auto_fwd = 1'b0;
    if (req.dist_center < oad_pkg::D_CENTER_NEAR) begin
      auto_pick = tog_r ? oad_pkg::ST_SPIN_R : oad_pkg::ST_SPIN_L;
    end else if ((req.dist_right_edge < oad_pkg::D_EDGE && req.dist_left_edge > oad_pkg::D_EDGE)
                 || req.dist_right_edge < oad_pkg::D_EDGE_CLOSE) begin
      auto_pick = oad_pkg::ST_LIGHT_R;
    end else if ((req.dist_right_edge > oad_pkg::D_EDGE && req.dist_left_edge < oad_pkg::D_EDGE)
                 || req.dist_left_edge < oad_pkg::D_EDGE_CLOSE) begin
      auto_pick = oad_pkg::ST_LIGHT_L;
    end else if (req.dist_right_edge < oad_pkg::D_EDGE && req.dist_left_edge < oad_pkg::D_EDGE) begin
      auto_pick = (req.dist_right_edge < req.dist_left_edge) ? oad_pkg::ST_CORR_R
                                                             : oad_pkg::ST_CORR_L;
    end else if (req.dist_right < oad_pkg::D_SIDE_NEAR && req.dist_left < oad_pkg::D_SIDE_NEAR) begin
      auto_pick = tog_r ? oad_pkg::ST_SPIN_R : oad_pkg::ST_SPIN_L;
    end else if (req.dist_right < oad_pkg::D_SIDE_FAR && req.dist_center > oad_pkg::D_CENTER_NEAR
                 && req.dist_left > oad_pkg::D_SIDE_FAR) begin
      auto_pick = oad_pkg::ST_TURN_L;
    end else if (req.dist_right > oad_pkg::D_SIDE_FAR && req.dist_center > oad_pkg::D_CENTER_NEAR
                 && req.dist_left < oad_pkg::D_SIDE_FAR) begin
      auto_pick = oad_pkg::ST_TURN_R;
    end else begin
      auto_pick = oad_pkg::ST_FWD;
      auto_fwd  = 1'b1;
    end
  end

  assign spin_s   = $signed({1'b0, spin_r});
  assign spin_neg = -spin_s;

  always_comb begin
    st_nxt    = st_r;
    auto_nxt  = auto_r;
    tog_nxt   = tog_r;
    timer_nxt = timer_r;
    rcmd_nxt  = rcmd_r;
    lcmd_nxt  = lcmd_r;
    leds_nxt  = leds_r;
    rep_nxt   = 1'b0;
    run_auto  = 1'b0;
    cur_run   = st_r;
    case (req.req_type)
      oad_pkg::REQ_TICK: begin
        timer_nxt = timer_sat;
        case (st_r)
          oad_pkg::ST_WAIT: begin
            // cleared timer can never exceed the limit here
            timer_nxt = 16'd0;
            auto_nxt  = 1'b1;
            rcmd_nxt  = 8'sd0;
            lcmd_nxt  = 8'sd0;
            st_nxt    = oad_pkg::ST_WAITING;
          end
          oad_pkg::ST_WAITING: begin
            if (timer_sat > wait_ms_r) st_nxt = oad_pkg::ST_FWD;
          end
          oad_pkg::ST_FWD: begin
            rcmd_nxt = fwd_s[7:0];
            lcmd_nxt = fwd_s[7:0];
            leds_nxt = fwd_leds;
            st_nxt   = oad_pkg::ST_FWD_RUN;
            cur_run  = oad_pkg::ST_FWD_RUN;
            run_auto = 1'b1;
          end
          oad_pkg::ST_TURN_L: begin
            rcmd_nxt = $signed({1'b0, turn_r});
            lcmd_nxt = 8'sd0;
            leds_nxt = oad_pkg::LED_W | oad_pkg::LED_B;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_TURN_R: begin
            rcmd_nxt = 8'sd0;
            lcmd_nxt = $signed({1'b0, turn_r});
            leds_nxt = oad_pkg::LED_O;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_SPIN_L: begin
            rcmd_nxt = spin_s;
            lcmd_nxt = spin_neg;
            leds_nxt = oad_pkg::LED_W | oad_pkg::LED_B | oad_pkg::LED_O;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_SPIN_R: begin
            rcmd_nxt = spin_neg;
            lcmd_nxt = spin_s;
            leds_nxt = oad_pkg::LED_W | oad_pkg::LED_B | oad_pkg::LED_O;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_STOP: begin
            rcmd_nxt = 8'sd0;
            lcmd_nxt = 8'sd0;
            leds_nxt = 3'b000;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_BACK: begin
            rcmd_nxt = rev_r;
            lcmd_nxt = rev_r;
            leds_nxt = 3'b000;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_CORR_L: begin
            rcmd_nxt = $signed({1'b0, light_r});
            lcmd_nxt = $signed({1'b0, corr_r});
            leds_nxt = oad_pkg::LED_W | oad_pkg::LED_B;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_CORR_R: begin
            rcmd_nxt = $signed({1'b0, corr_r});
            lcmd_nxt = $signed({1'b0, light_r});
            leds_nxt = oad_pkg::LED_O;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_LIGHT_L: begin
            rcmd_nxt = $signed({1'b0, light_r});
            lcmd_nxt = 8'sd0;
            leds_nxt = oad_pkg::LED_W | oad_pkg::LED_O;
            st_nxt   = st_r + 5'd1;
          end
          oad_pkg::ST_LIGHT_R: begin
            rcmd_nxt = 8'sd0;
            lcmd_nxt = $signed({1'b0, light_r});
            leds_nxt = oad_pkg::LED_W | oad_pkg::LED_O;
            st_nxt   = st_r + 5'd1;
          end
          default: begin
            // in-progress states run the classifier, unused codes drop to stop
            if (st_r <= oad_pkg::ST_LAST) begin
              run_auto = 1'b1;
            end else begin
              st_nxt = oad_pkg::ST_STOP;
            end
          end
        endcase
        if (run_auto && auto_r) begin
          if (auto_fwd) tog_nxt = !tog_r;
          if ((auto_pick + 5'd1) != cur_run) begin
            st_nxt  = auto_pick;
            rep_nxt = 1'b1;
          end
        end
      end
      oad_pkg::REQ_AUTO: begin
        auto_nxt = (req.cmd_value == 8'd1);
        st_nxt   = (req.cmd_value == 8'd1) ? oad_pkg::ST_WAIT : oad_pkg::ST_STOP;
      end
      oad_pkg::REQ_SET: begin
        st_nxt = (req.cmd_value > {3'b000, oad_pkg::ST_MAX}) ? oad_pkg::ST_MAX
                                                           : req.cmd_value[4:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= oad_pkg::ST_WAIT;
      auto_r      <= 1'b1;
      tog_r       <= 1'b1;
      timer_r     <= 16'd0;
      rcmd_r      <= 8'sd0;
      lcmd_r      <= 8'sd0;
      leds_r      <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r    <= st_nxt;
        auto_r  <= auto_nxt;
        tog_r   <= tog_nxt;
        timer_r <= timer_nxt;
        rcmd_r  <= rcmd_nxt;
        lcmd_r  <= lcmd_nxt;
        leds_r  <= leds_nxt;
      end
      out_valid_r <= in_acc || (out_valid_r && !out_ch.ready);
    end
  end

  // result register, no reset needed on payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r.state_code   <= st_nxt;
      out_r.right_speed  <= rcmd_nxt;
      out_r.left_speed   <= lcmd_nxt;
      out_r.led_white    <= leds_nxt[0];
      out_r.led_blue     <= leds_nxt[1];
      out_r.led_amber    <= leds_nxt[2];
      out_r.auto_mode    <= auto_nxt;
      out_r.state_report <= rep_nxt;
    end
  end

endmodule

@@ test/oad_checker.sv @@
`timescale 1ns / 100ps

module oad_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  oad_in_if                              in_ch,
  oad_out_if                             out_ch,
  input  logic                           cfg_wr_en,
  input  oad_pkg::cfg_idx_t              cfg_index,
  input  logic [oad_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  localparam logic [7:0] CENTER_NEAR = 8'd20;
  localparam logic [7:0] EDGE_NEAR   = 8'd10;
  localparam logic [7:0] EDGE_TOUCH  = 8'd5;
  localparam logic [7:0] SIDE_NEAR   = 8'd20;
  localparam logic [7:0] SIDE_FAR    = 8'd30;
  localparam int         SPEED_TRIM  = 10;
  localparam int         BLUE_SPEED  = 30;
  localparam int         WHITE_SPEED = 20;

  // register copies
  logic [6:0]        turn_r, spin_r, light_r, corr_r, max_r, min_r;
  logic signed [7:0] rev_r;
  logic [15:0]       wait_r;

  // drive controller state
  oad_pkg::state_code_t drv_state;
  logic              auto_en;
  logic              spin_tog;
  logic [15:0]       wait_tmr;
  logic signed [7:0] right_q, left_q;
  logic [2:0]        leds_q;
  logic              reported;

  oad_pkg::out_item_t drive_q[$];
  int                errs = 0;
  int                n_checked = 0;

  assign fail_count = errs;
  assign checked    = n_checked;

  function automatic void latch(logic signed [7:0] r, logic signed [7:0] l,
                                logic [2:0] leds, oad_pkg::state_code_t nxt);
    right_q   = r;
    left_q    = l;
    leds_q    = leds;
    drv_state = nxt;
  endfunction

  function automatic void steer(oad_pkg::in_item_t it);
    oad_pkg::state_code_t nxt;
    logic [7:0]  re, rr, c, ll, le;
    re = it.dist_right_edge;
    rr = it.dist_right;
    c  = it.dist_center;
    ll = it.dist_left;
    le = it.dist_left_edge;
    if (!auto_en) return;
    if (c < CENTER_NEAR) begin
      nxt = spin_tog ? oad_pkg::ST_SPIN_R : oad_pkg::ST_SPIN_L;
    end else if ((re < EDGE_NEAR && le > EDGE_NEAR) || re < EDGE_TOUCH) begin
      nxt = oad_pkg::ST_LIGHT_R;
    end else if ((re > EDGE_NEAR && le < EDGE_NEAR) || le < EDGE_TOUCH) begin
      nxt = oad_pkg::ST_LIGHT_L;
    end else if (re < EDGE_NEAR && le < EDGE_NEAR) begin
      nxt = (re < le) ? oad_pkg::ST_CORR_R : oad_pkg::ST_CORR_L;
    end else if (rr < SIDE_NEAR && ll < SIDE_NEAR) begin
      nxt = spin_tog ? oad_pkg::ST_SPIN_R : oad_pkg::ST_SPIN_L;
    end else if (rr < SIDE_FAR && c > CENTER_NEAR && ll > SIDE_FAR) begin
      nxt = oad_pkg::ST_TURN_L;
    end else if (rr > SIDE_FAR && c > CENTER_NEAR && ll < SIDE_FAR) begin
      nxt = oad_pkg::ST_TURN_R;
    end else begin
      // clear path: keep going and flip the spin direction
      nxt      = oad_pkg::ST_FWD;
      spin_tog = ~spin_tog;
    end
    if (nxt + 5'd1 != drv_state) begin
      drv_state = nxt;
      reported  = 1'b1;
    end
  endfunction

  function automatic logic signed [7:0] fwd_speed(oad_pkg::in_item_t it);
    logic [7:0] m;
    int         s;
    m = it.dist_right_edge;
    if (it.dist_right < m) m = it.dist_right;
    if (it.dist_center < m) m = it.dist_center;
    if (it.dist_left < m) m = it.dist_left;
    if (it.dist_left_edge < m) m = it.dist_left_edge;
    s = int'(m) - SPEED_TRIM;
    // max clamp wins over min clamp
    if (s > int'(max_r)) s = int'(max_r);
    else if (s < int'(min_r)) s = int'(min_r);
    return s[7:0];
  endfunction

  function automatic oad_pkg::out_item_t predict(oad_pkg::in_item_t it);
    oad_pkg::out_item_t res;
    logic [16:0]       sum;
    logic signed [7:0] spd;
    logic signed [7:0] turn_s, spin_s, light_s, corr_s;
    turn_s   = $signed({1'b0, turn_r});
    spin_s   = $signed({1'b0, spin_r});
    light_s  = $signed({1'b0, light_r});
    corr_s   = $signed({1'b0, corr_r});
    reported = 1'b0;
    case (it.req_type)
      oad_pkg::REQ_TICK: begin
        sum      = {1'b0, wait_tmr} + {9'd0, it.ms_delta};
        wait_tmr = sum[16] ? 16'hFFFF : sum[15:0];
        case (drv_state)
          oad_pkg::ST_WAIT: begin
            // timer restarts at zero, so it cannot expire on entry
            wait_tmr  = '0;
            auto_en   = 1'b1;
            right_q   = '0;
            left_q    = '0;
            drv_state = oad_pkg::ST_WAITING;
          end
          oad_pkg::ST_WAITING: if (wait_tmr > wait_r) drv_state = oad_pkg::ST_FWD;
          oad_pkg::ST_FWD: begin
            spd = fwd_speed(it);
            latch(spd, spd,
                  (spd >= BLUE_SPEED) ? oad_pkg::LED_B
                                      : ((spd >= WHITE_SPEED) ? oad_pkg::LED_W : 3'b000),
                  oad_pkg::ST_FWD_RUN);
            steer(it);
          end
          oad_pkg::ST_TURN_L:
            latch(turn_s, 8'sd0, oad_pkg::LED_W | oad_pkg::LED_B, oad_pkg::ST_TURN_L + 5'd1);
          oad_pkg::ST_TURN_R:
            latch(8'sd0, turn_s, oad_pkg::LED_O, oad_pkg::ST_TURN_R + 5'd1);
          oad_pkg::ST_SPIN_L:
            latch(spin_s, -spin_s, oad_pkg::LED_W | oad_pkg::LED_B | oad_pkg::LED_O,
                  oad_pkg::ST_SPIN_L + 5'd1);
          oad_pkg::ST_SPIN_R:
            latch(-spin_s, spin_s, oad_pkg::LED_W | oad_pkg::LED_B | oad_pkg::LED_O,
                  oad_pkg::ST_SPIN_R + 5'd1);
          oad_pkg::ST_STOP:
            latch(8'sd0, 8'sd0, 3'b000, oad_pkg::ST_STOP + 5'd1);
          oad_pkg::ST_BACK:
            latch(rev_r, rev_r, 3'b000, oad_pkg::ST_BACK + 5'd1);
          oad_pkg::ST_CORR_L:
            latch(light_s, corr_s, oad_pkg::LED_W | oad_pkg::LED_B, oad_pkg::ST_CORR_L + 5'd1);
          oad_pkg::ST_CORR_R:
            latch(corr_s, light_s, oad_pkg::LED_O, oad_pkg::ST_CORR_R + 5'd1);
          oad_pkg::ST_LIGHT_L:
            latch(light_s, 8'sd0, oad_pkg::LED_W | oad_pkg::LED_O, oad_pkg::ST_LIGHT_L + 5'd1);
          oad_pkg::ST_LIGHT_R:
            latch(8'sd0, light_s, oad_pkg::LED_W | oad_pkg::LED_O, oad_pkg::ST_LIGHT_R + 5'd1);
          default: begin
            // codes past the last in-progress state fall back to stop
            if (drv_state <= oad_pkg::ST_LAST) steer(it);
            else drv_state = oad_pkg::ST_STOP;
          end
        endcase
      end
      oad_pkg::REQ_AUTO: begin
        auto_en   = (it.cmd_value == 8'd1);
        drv_state = auto_en ? oad_pkg::ST_WAIT : oad_pkg::ST_STOP;
      end
      oad_pkg::REQ_SET:
        drv_state = (it.cmd_value > 8'(oad_pkg::ST_MAX)) ? oad_pkg::ST_MAX
                                                          : it.cmd_value[4:0];
      default: ;
    endcase
    res.state_code   = drv_state;
    res.right_speed  = right_q;
    res.left_speed   = left_q;
    res.led_white    = leds_q[0];
    res.led_blue     = leds_q[1];
    res.led_amber    = leds_q[2];
    res.auto_mode    = auto_en;
    res.state_report = reported;
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    oad_pkg::out_item_t want, got;
    if (!rst_n) begin
      turn_r    = 7'd15;
      spin_r    = 7'd15;
      rev_r     = -8'sd15;
      light_r   = 7'd20;
      corr_r    = 7'd25;
      max_r     = 7'd40;
      min_r     = 7'd0;
      wait_r    = 16'd1000;
      drv_state = oad_pkg::ST_WAIT;
      auto_en   = 1'b1;
      spin_tog  = 1'b1;
      wait_tmr  = '0;
      right_q   = '0;
      left_q    = '0;
      leds_q    = '0;
      reported  = 1'b0;
      drive_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          oad_pkg::CFG_TURN:     turn_r  = cfg_wdata[6:0];
          oad_pkg::CFG_SPIN:     spin_r  = cfg_wdata[6:0];
          oad_pkg::CFG_REVERSE:  rev_r   = cfg_wdata[7:0];
          oad_pkg::CFG_LIGHT:    light_r = cfg_wdata[6:0];
          oad_pkg::CFG_CORRIDOR: corr_r  = cfg_wdata[6:0];
          oad_pkg::CFG_MAX:      max_r   = cfg_wdata[6:0];
          oad_pkg::CFG_MIN:      min_r   = cfg_wdata[6:0];
          oad_pkg::CFG_WAIT:     wait_r  = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (drive_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = drive_q.pop_front();
          n_checked++;
          check_field("state_code", want.state_code, got.state_code);
          check_field("right_speed", want.right_speed, got.right_speed);
          check_field("left_speed", want.left_speed, got.left_speed);
          check_field("led_white", want.led_white, got.led_white);
          check_field("led_blue", want.led_blue, got.led_blue);
          check_field("led_amber", want.led_amber, got.led_amber);
          check_field("auto_mode", want.auto_mode, got.auto_mode);
          check_field("state_report", want.state_report, got.state_report);
        end
      end
      if (in_ch.valid && in_ch.ready) drive_q.push_back(predict(in_ch.payload));
    end
    pending <= drive_q.size();
  end

endmodule

@@ test/obstacle_avoid_drive_fsm_tb.sv @@
`timescale 1ns / 100ps

module obstacle_avoid_drive_fsm_tb;

  localparam oad_pkg::req_t REQ_UNUSED = 2'd3;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   DRAIN_CYCLES = 4;
  localparam int   OPEN         = 100;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_wr_en;
  oad_pkg::cfg_idx_t              cfg_index;
  logic [oad_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           rx_ready = 1'b0;
  logic [15:0]                    rx_cnt = '0;
  int                             fail_count, pending, checked;
  int                             cycle_cnt = 0;
  int                             sent = 0, directed_n = 0, settings_n = 0, burst_left = 0;

  oad_in_if  in_if ();
  oad_out_if out_if ();

  assign out_if.ready = rx_ready;

  obstacle_avoid_drive_fsm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  oad_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL obstacle_avoid_drive_fsm");
      $finish;
    end
  end

  // receiver: rotate through always-ready, random and periodic stalls
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 16'd1;
    case (rx_cnt[8:7])
      2'd0:    rx_ready <= 1'b1;
      2'd1:    rx_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    rx_ready <= (rx_cnt[2:0] < 3'd5);
      default: rx_ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  function automatic logic [7:0] pick_dist();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 12));
      1:       return 8'($urandom_range(15, 35));
      2:       return 8'($urandom_range(36, 80));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic oad_pkg::in_item_t rand_fill();
    oad_pkg::in_item_t it;
    it.req_type        = oad_pkg::REQ_TICK;
    it.cmd_value       = 8'($urandom);
    it.dist_right_edge = pick_dist();
    it.dist_right      = pick_dist();
    it.dist_center     = pick_dist();
    it.dist_left       = pick_dist();
    it.dist_left_edge  = pick_dist();
    it.ms_delta        = 8'($urandom);
    return it;
  endfunction

  // mostly ticks; set-state, set-auto and the unused code mixed in
  function automatic oad_pkg::in_item_t rand_req();
    oad_pkg::in_item_t it;
    int       sel;
    it  = rand_fill();
    sel = $urandom_range(0, 99);
    if (sel >= 96) begin
      it.req_type = REQ_UNUSED;
    end else if (sel >= 90) begin
      it.req_type = oad_pkg::REQ_AUTO;
      if ($urandom_range(0, 3) != 0) it.cmd_value = 8'd1;
    end else if (sel >= 84) begin
      it.req_type = oad_pkg::REQ_SET;
      if ($urandom_range(0, 3) != 0) it.cmd_value = 8'($urandom_range(0, 23));
    end
    return it;
  endfunction

  task automatic push_req(input oad_pkg::in_item_t it);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic tick(input int re, rr, c, ll, le, ms);
    oad_pkg::in_item_t it;
    it                 = rand_fill();
    it.dist_right_edge = 8'(re);
    it.dist_right      = 8'(rr);
    it.dist_center     = 8'(c);
    it.dist_left       = 8'(ll);
    it.dist_left_edge  = 8'(le);
    it.ms_delta        = 8'(ms);
    push_req(it);
    directed_n++;
  endtask

  task automatic command(input oad_pkg::req_t rq, input int val);
    oad_pkg::in_item_t it;
    it           = rand_fill();
    it.req_type  = rq;
    it.cmd_value = 8'(val);
    push_req(it);
    directed_n++;
  endtask

  // drop valid and hold until every request has its result
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input oad_pkg::cfg_idx_t idx, input int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= oad_pkg::CFG_DATA_W'(data);
    @(posedge clk);
  endtask

  task automatic load_regs(input int turn, spin, rev, light, corr, top, floor, hold);
    cfg_write(oad_pkg::CFG_TURN, turn);
    cfg_write(oad_pkg::CFG_SPIN, spin);
    cfg_write(oad_pkg::CFG_REVERSE, rev & 'hFF);
    cfg_write(oad_pkg::CFG_LIGHT, light);
    cfg_write(oad_pkg::CFG_CORRIDOR, corr);
    cfg_write(oad_pkg::CFG_MAX, top);
    cfg_write(oad_pkg::CFG_MIN, floor);
    cfg_write(oad_pkg::CFG_WAIT, hold);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    settings_n++;
  endtask

  task automatic run_random(input int n);
    repeat (n) push_req(rand_req());
    settle();
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= oad_pkg::CFG_TURN;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // wait entry, then let the timer run past the default wait
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    repeat (4) tick(OPEN, OPEN, OPEN, OPEN, OPEN, 255);
    // forward with far readings clamps to max speed, clear path flips the toggle
    tick(255, 255, 255, 255, 255, 0);
    tick(OPEN, OPEN, 10, OPEN, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(3, OPEN, OPEN, OPEN, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, 3, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(8, OPEN, OPEN, OPEN, 7, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(OPEN, 15, OPEN, 15, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(OPEN, 25, 50, 50, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(OPEN, 50, 50, 25, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    command(oad_pkg::REQ_SET, oad_pkg::ST_BACK);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    // out-of-range set-state saturates, then decays to stop
    command(oad_pkg::REQ_SET, 200);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    tick(OPEN, OPEN, OPEN, OPEN, OPEN, 0);
    command(oad_pkg::REQ_AUTO, 0);
    command(REQ_UNUSED, 0);
    command(oad_pkg::REQ_AUTO, 1);
    // short reading drives forward speed below the floor
    command(oad_pkg::REQ_SET, oad_pkg::ST_FWD);
    tick(5, 5, 5, 5, 5, 0);
    settle();

    load_regs(15, 15, -15, 20, 25, 40, 0, 1000);
    run_random(120);
    load_regs(0, 0, -100, 0, 0, 0, 0, 0);
    run_random(110);
    // wait never expires here
    load_regs(100, 100, 100, 100, 100, 100, 100, 65535);
    run_random(110);
    // floor above ceiling
    load_regs(60, 30, -40, 45, 70, 20, 50, 300);
    run_random(110);
    repeat (2) begin
      load_regs($urandom_range(0, 100), $urandom_range(0, 100),
                int'($urandom_range(0, 200)) - 100, $urandom_range(0, 100),
                $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 100),
                ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2000)
                                            : $urandom_range(0, 65535));
      run_random(125);
    end

    $display("Covered %0d requests (%0d directed) under %0d register settings",
             sent, directed_n, settings_n);
    $display("Compared %0d results, %0d field mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS obstacle_avoid_drive_fsm");
    end else begin
      $display("FAIL obstacle_avoid_drive_fsm");
    end
    $finish;
  end

endmodule
